// ===== src/crcdf_pkg.sv =====
// Shared types, codes and the CRC-32 byte update for the record deframer.
package crcdf_pkg;

	// Parser phase
	typedef enum logic [1:0] {
		PH_LEN  = 2'd0,
		PH_CRC  = 2'd1,
		PH_PAY  = 2'd2,
		PH_DEAD = 2'd3
	} phase_t;

	// Record verdict codes
	typedef enum logic [2:0] {
		ST_GOOD    = 3'd0,
		ST_CRC_BAD = 3'd1,
		ST_ID_LONG = 3'd2,
		ST_BAD_LEN = 3'd3,
		ST_TORN    = 3'd4
	} status_t;

	// Payload part tags
	typedef enum logic [1:0] {
		PART_ID_LEN = 2'd0,
		PART_ID     = 2'd1,
		PART_BODY   = 2'd2
	} part_t;

	localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
	localparam logic [31:0] CRC_PRESET    = 32'hFFFFFFFF;
	localparam logic [31:0] MAX_LEN_RESET = 32'd1048576;
	localparam logic [31:0] COUNT_MAX     = 32'hFFFFFFFF;

	// Reflected CRC-32 update by one byte (an XOR network after unrolling)
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
			input logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== src/crcdf_if.sv =====
// Channel interfaces: segment input stream and record result stream.
interface crcdf_seg_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] data_byte;

	modport source (output valid, output action, output data_byte, input ready);
	modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface crcdf_rec_if import crcdf_pkg::*;;
	logic        valid;
	logic        ready;
	logic        has_byte;
	logic [7:0]  byte_value;
	part_t       payload_part;
	logic        record_done;
	status_t     status;
	logic [31:0] record_length;
	logic [31:0] corrupt_skipped;

	modport source (output valid, output has_byte, output byte_value, output payload_part,
		output record_done, output status, output record_length, output corrupt_skipped,
		input ready);
	modport sink (input valid, input has_byte, input byte_value, input payload_part,
		input record_done, input status, input record_length, input corrupt_skipped,
		output ready);
endinterface

// ===== src/crc32_record_deframer.sv =====
// Length-prefixed record deframer with CRC-32 check.
//
// seg carries one transfer per segment byte (action 0) or per end of segment
// (action 1). rec carries at most one result per seg transfer: each payload
// byte tagged with its part, a verdict on the last payload byte, a bad-length
// abandonment or a torn record at end of segment. Other header bytes give none.
// cfg_wr_en/cfg_wr_data write max_record_length; write only while idle.
// A result is registered and appears on rec in the cycle after its seg transfer.
// Throughput: one seg transfer per cycle; all parsing and the table-free CRC
// byte update sit between the parser state registers and the result register.
// The result register frees as it drains, so seg.ready stays high while rec
// is taken every cycle. When rec stalls with a result held, seg.ready drops
// until that result is taken; nothing is lost or repeated.
// Reset (arst_n low): parser returns to the length header, CRC to all ones,
// skipped count to zero, max_record_length to 1048576, no result pending.
module crc32_record_deframer import crcdf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	crcdf_seg_if.sink   seg,
	crcdf_rec_if.source rec
);

	// Parser state
	phase_t      phase_q, phase_n;
	logic [1:0]  hdr_cnt_q, hdr_cnt_n;
	logic [31:0] pay_len_q, pay_len_n;
	logic [31:0] exp_crc_q, exp_crc_n;
	logic [31:0] run_crc_q, run_crc_n;
	logic [31:0] pay_cnt_q, pay_cnt_n;
	logic [15:0] bid_len_q, bid_len_n;
	logic [31:0] skipped_q, skipped_n;
	logic [31:0] max_len_q;

	// Result register
	logic        out_valid_q;
	logic        has_byte_q;
	logic [7:0]  byte_value_q;
	part_t       part_q;
	logic        done_q;
	status_t     status_q;
	logic [31:0] rec_len_q;
	logic [31:0] skip_out_q;

	// Combinational result
	logic        res_valid;
	logic        res_has_byte;
	logic [7:0]  res_byte;
	part_t       res_part;
	logic        res_done;
	status_t     res_status;
	logic [31:0] res_len;

	logic        xfer;
	logic [7:0]  b;
	logic [31:0] byte_shifted;
	logic [31:0] len_asm;
	logic [31:0] crc_asm;
	logic        len_bad;
	logic        hdr_last;
	logic [31:0] crc_upd;
	logic [15:0] bid_upd;
	logic [31:0] cnt_inc;
	logic        pay_last;
	logic        crc_bad;
	logic        id_long;
	logic        torn;
	part_t       pay_part;

	assign seg.ready = !out_valid_q || rec.ready;
	assign xfer      = seg.valid && seg.ready;
	assign b         = seg.data_byte;

	// Header assembly, little-endian
	assign byte_shifted = {24'd0, b} << {hdr_cnt_q, 3'b000};
	assign len_asm      = pay_len_q | byte_shifted;
	assign crc_asm      = exp_crc_q | byte_shifted;
	assign hdr_last     = (hdr_cnt_q == 2'd3);
	assign len_bad      = (len_asm < 32'd2) || (len_asm > max_len_q);

	// Payload byte processing
	assign crc_upd  = crc32_byte(run_crc_q, b);
	assign cnt_inc  = pay_cnt_q + 32'd1;
	assign pay_last = (cnt_inc == pay_len_q);
	always_comb begin
		bid_upd  = bid_len_q;
		pay_part = PART_BODY;
		if (pay_cnt_q == 32'd0) begin
			bid_upd  = {8'd0, b};
			pay_part = PART_ID_LEN;
		end else if (pay_cnt_q == 32'd1) begin
			bid_upd  = {b, bid_len_q[7:0]};
			pay_part = PART_ID_LEN;
		end else if ({1'b0, pay_cnt_q} < ({17'd0, bid_len_q} + 33'd2)) begin
			pay_part = PART_ID;
		end
	end
	assign crc_bad = ((crc_upd ^ CRC_PRESET) != exp_crc_q);
	assign id_long = (({17'd0, bid_upd} + 33'd2) > {1'b0, pay_len_q});

	assign torn = (phase_q == PH_CRC) || (phase_q == PH_PAY) ||
		((phase_q == PH_LEN) && (hdr_cnt_q != 2'd0));

	// Next parser state
	always_comb begin
		phase_n   = phase_q;
		hdr_cnt_n = hdr_cnt_q;
		pay_len_n = pay_len_q;
		exp_crc_n = exp_crc_q;
		run_crc_n = run_crc_q;
		pay_cnt_n = pay_cnt_q;
		bid_len_n = bid_len_q;
		skipped_n = skipped_q;
		if (seg.action) begin
			phase_n   = PH_LEN;
			hdr_cnt_n = 2'd0;
			pay_len_n = 32'd0;
			exp_crc_n = 32'd0;
			run_crc_n = CRC_PRESET;
			pay_cnt_n = 32'd0;
			bid_len_n = 16'd0;
		end else begin
			case (phase_q)
				PH_LEN: begin
					pay_len_n = len_asm;
					hdr_cnt_n = hdr_cnt_q + 2'd1;
					if (hdr_last) begin
						phase_n = len_bad ? PH_DEAD : PH_CRC;
					end
				end
				PH_CRC: begin
					exp_crc_n = crc_asm;
					hdr_cnt_n = hdr_cnt_q + 2'd1;
					if (hdr_last) begin
						phase_n = PH_PAY;
					end
				end
				PH_PAY: begin
					if (!pay_last) begin
						run_crc_n = crc_upd;
						bid_len_n = bid_upd;
						pay_cnt_n = cnt_inc;
					end else begin
						if ((crc_bad || id_long) && (skipped_q != COUNT_MAX)) begin
							skipped_n = skipped_q + 32'd1;
						end
						phase_n   = PH_LEN;
						hdr_cnt_n = 2'd0;
						pay_len_n = 32'd0;
						exp_crc_n = 32'd0;
						run_crc_n = CRC_PRESET;
						pay_cnt_n = 32'd0;
						bid_len_n = 16'd0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Result fields
	always_comb begin
		res_valid    = 1'b0;
		res_has_byte = 1'b0;
		res_byte     = 8'd0;
		res_part     = PART_ID_LEN;
		res_done     = 1'b0;
		res_status   = ST_GOOD;
		res_len      = 32'd0;
		if (seg.action) begin
			res_valid  = torn;
			res_done   = 1'b1;
			res_status = ST_TORN;
			res_len    = (phase_q == PH_LEN) ? 32'd0 : pay_len_q;
		end else begin
			case (phase_q)
				PH_LEN: begin
					if (hdr_last && len_bad) begin
						res_valid  = 1'b1;
						res_done   = 1'b1;
						res_status = ST_BAD_LEN;
						res_len    = len_asm;
					end
				end
				PH_PAY: begin
					res_valid    = 1'b1;
					res_has_byte = 1'b1;
					res_byte     = b;
					res_part     = pay_part;
					res_len      = pay_len_q;
					if (pay_last) begin
						res_done = 1'b1;
						if (crc_bad) begin
							res_status = ST_CRC_BAD;
						end else if (id_long) begin
							res_status = ST_ID_LONG;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEN;
			hdr_cnt_q   <= 2'd0;
			pay_len_q   <= 32'd0;
			exp_crc_q   <= 32'd0;
			run_crc_q   <= CRC_PRESET;
			pay_cnt_q   <= 32'd0;
			bid_len_q   <= 16'd0;
			skipped_q   <= 32'd0;
			max_len_q   <= MAX_LEN_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				max_len_q <= cfg_wr_data;
			end
			if (xfer) begin
				phase_q     <= phase_n;
				hdr_cnt_q   <= hdr_cnt_n;
				pay_len_q   <= pay_len_n;
				exp_crc_q   <= exp_crc_n;
				run_crc_q   <= run_crc_n;
				pay_cnt_q   <= pay_cnt_n;
				bid_len_q   <= bid_len_n;
				skipped_q   <= skipped_n;
				out_valid_q <= res_valid;
			end else if (rec.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload register
	always_ff @(posedge clk) begin
		if (xfer && res_valid) begin
			has_byte_q   <= res_has_byte;
			byte_value_q <= res_byte;
			part_q       <= res_part;
			done_q       <= res_done;
			status_q     <= res_status;
			rec_len_q    <= res_len;
			skip_out_q   <= skipped_n;
		end
	end

	assign rec.valid           = out_valid_q;
	assign rec.has_byte        = has_byte_q;
	assign rec.byte_value      = byte_value_q;
	assign rec.payload_part    = part_q;
	assign rec.record_done     = done_q;
	assign rec.status          = status_q;
	assign rec.record_length   = rec_len_q;
	assign rec.corrupt_skipped = skip_out_q;

	// Skipped count never goes down
	a_skip_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (skipped_q >= $past(skipped_q)))
		else $error("skipped count decreased");

	// Abandoned segment stays abandoned until end of segment
	a_dead_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && !seg.action && (phase_q == PH_DEAD)) |=>
		((phase_q == PH_DEAD) && !out_valid_q))
		else $error("data byte after abandonment changed state or gave a result");

	// Header byte counter only runs in the header phases
	a_hdr_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(hdr_cnt_q != 2'd0) |-> ((phase_q == PH_LEN) || (phase_q == PH_CRC)))
		else $error("header count set outside header phase");

	// End of segment always returns the parser to the length header
	a_eos_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && seg.action) |=> ((phase_q == PH_LEN) && (hdr_cnt_q == 2'd0) &&
		(pay_cnt_q == 32'd0)))
		else $error("end of segment did not restart parser");

endmodule
